/* sv/trc_pkg.sv */
// shared constants and types for the tag read coalescer
package trc_pkg;

  localparam int RUN_COUNT_BITS = 16;
  localparam int TIME_BITS      = 40;

  localparam int ID_W        = 64;
  localparam int ANT_W       = 4;
  localparam int CNT_W       = 8;
  localparam int SIG_W       = 10;
  localparam int SPD_W       = 16;
  localparam int HDG_W       = 2;
  localparam int TS_W        = 40;
  localparam int READS_W     = 16;
  localparam int RSSI_SUM_W  = 26;
  localparam int SPEED_SUM_W = 32;
  localparam int RSSI_OUT_W  = 11;

  localparam int TIME_W = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;

  localparam int DIV_W          = 32;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_END   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_START  = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

endpackage

/* sv/trc_in_if.sv */
// input channel carrying one tag read transaction
interface trc_in_if;
  import trc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [ID_W-1:0]   tag_id_hi;
  logic [ID_W-1:0]   tag_id_lo;
  logic [ANT_W-1:0]  antenna;
  logic [CNT_W-1:0]  read_count;
  logic [SIG_W-1:0]  signal_level;
  logic [SPD_W-1:0]  speed;
  logic [HDG_W-1:0]  heading;
  logic [TS_W-1:0]   timestamp;

  modport source (
    output valid, func, tag_id_hi, tag_id_lo, antenna, read_count, signal_level,
           speed, heading, timestamp,
    input  ready
  );

  modport sink (
    input  valid, func, tag_id_hi, tag_id_lo, antenna, read_count, signal_level,
           speed, heading, timestamp,
    output ready
  );

endinterface

/* sv/trc_out_if.sv */
// result channel carrying one merged record or marker transaction
interface trc_out_if;
  import trc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   record_kind;
  logic [ID_W-1:0]              out_id_hi;
  logic [ID_W-1:0]              out_id_lo;
  logic [ANT_W-1:0]             out_antenna;
  logic [READS_W-1:0]           total_reads;
  logic signed [RSSI_OUT_W-1:0] mean_rssi;
  logic [SPD_W-1:0]             mean_speed;
  logic [HDG_W-1:0]             out_heading;
  logic [TS_W-1:0]              first_seen;
  logic [TS_W-1:0]              last_seen;
  logic                         last_of_run;

  modport source (
    output valid, record_kind, out_id_hi, out_id_lo, out_antenna, total_reads,
           mean_rssi, mean_speed, out_heading, first_seen, last_seen, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, record_kind, out_id_hi, out_id_lo, out_antenna, total_reads,
           mean_rssi, mean_speed, out_heading, first_seen, last_seen, last_of_run,
    output ready
  );

endinterface

/* sv/tag_read_coalescer.sv */
// tag read coalescer top level: merges runs of identical tag reads into records
//
// Reads with the same 128-bit tag id and antenna are folded into one pending
// record; a differing read, or an end marker, releases that record with the
// saturated read total, the negated mean RSSI, the mean speed, the first heading
// and the first and last times. A start marker drops the pending record, an end
// marker keeps it. The block takes one transaction at a time: a read that only
// extends the run or opens one from nothing is folded in while idle, a marker
// with no record waits only for the sink, and a transaction that releases a
// record first runs one shared radix-4 restoring divider for the RSSI mean and
// then for the speed mean, then waits for the sink, an end marker sending its
// own marker after the record.
module tag_read_coalescer (
  input  logic      clk,
  input  logic      rst_n,
  trc_in_if.sink    in_chan,
  trc_out_if.source out_chan
);
  import trc_pkg::*;

  localparam int RCB = RUN_COUNT_BITS;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_DIV_RSSI  = 5'b00010,
    S_DIV_SPEED = 5'b00100,
    S_REC       = 5'b01000,
    S_MARK      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // latched transaction
  logic [1:0]       func_r, func_nxt;
  logic [ID_W-1:0]  in_hi_r, in_hi_nxt;
  logic [ID_W-1:0]  in_lo_r, in_lo_nxt;
  logic [ANT_W-1:0] in_ant_r, in_ant_nxt;
  logic [CNT_W-1:0] in_cnt_r, in_cnt_nxt;
  logic [SIG_W-1:0] in_sig_r, in_sig_nxt;
  logic [SPD_W-1:0] in_spd_r, in_spd_nxt;
  logic [HDG_W-1:0] in_hdg_r, in_hdg_nxt;
  logic [TIME_W-1:0] in_time_r, in_time_nxt;

  // pending record
  logic                   pend_r, pend_nxt;
  logic [ID_W-1:0]        id_hi_r, id_hi_nxt;
  logic [ID_W-1:0]        id_lo_r, id_lo_nxt;
  logic [ANT_W-1:0]       ant_r, ant_nxt;
  logic [READS_W-1:0]     reads_r, reads_nxt;
  logic [RSSI_SUM_W-1:0]  rssi_sum_r, rssi_sum_nxt;
  logic [SPEED_SUM_W-1:0] speed_sum_r, speed_sum_nxt;
  logic [RCB-1:0]         run_len_r, run_len_nxt;
  logic [HDG_W-1:0]       hdg_r, hdg_nxt;
  logic [TIME_W-1:0]      t_first_r, t_first_nxt;
  logic [TIME_W-1:0]      t_last_r, t_last_nxt;

  // shared divider
  logic [RCB:0]           rem_r, rem_nxt;
  logic [DIV_W-1:0]       quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [SIG_W-1:0]       rssi_q_r, rssi_q_nxt;

  // output register
  logic [1:0]                   o_kind_r, o_kind_nxt;
  logic [ID_W-1:0]              o_hi_r, o_hi_nxt;
  logic [ID_W-1:0]              o_lo_r, o_lo_nxt;
  logic [ANT_W-1:0]             o_ant_r, o_ant_nxt;
  logic [READS_W-1:0]           o_reads_r, o_reads_nxt;
  logic signed [RSSI_OUT_W-1:0] o_rssi_r, o_rssi_nxt;
  logic [SPD_W-1:0]             o_spd_r, o_spd_nxt;
  logic [HDG_W-1:0]             o_hdg_r, o_hdg_nxt;
  logic [TS_W-1:0]              o_first_r, o_first_nxt;
  logic [TS_W-1:0]              o_last_r, o_last_nxt;
  logic                         o_lor_r, o_lor_nxt;

  logic                 in_acc;
  logic                 out_acc;
  logic                 is_idle;
  logic                 match;
  logic [RCB-1:0]       divisor;
  logic [RCB:0]         step_rem;
  logic [DIV_W-1:0]     step_quo;
  logic                 div_last;
  logic                 do_load;
  logic                 do_mark;
  logic [READS_W:0]     reads_add;
  logic [RSSI_SUM_W:0]  rssi_add;
  logic [SPEED_SUM_W:0] speed_add;
  logic [SIG_W-1:0]     rssi_mean;
  logic [SPD_W-1:0]     speed_mean;

  // load and marker sources: live input when idle, latched copy otherwise
  logic [1:0]        src_func;
  logic [ID_W-1:0]   src_hi;
  logic [ID_W-1:0]   src_lo;
  logic [ANT_W-1:0]  src_ant;
  logic [CNT_W-1:0]  src_cnt;
  logic [SIG_W-1:0]  src_sig;
  logic [SPD_W-1:0]  src_spd;
  logic [HDG_W-1:0]  src_hdg;
  logic [TIME_W-1:0] src_time;

  assign is_idle       = (state_r == S_IDLE);
  assign in_chan.ready = is_idle;
  assign in_acc        = in_chan.valid && is_idle;
  assign out_chan.valid = (state_r == S_REC) || (state_r == S_MARK);
  assign out_acc       = out_chan.valid && out_chan.ready;

  assign src_func = is_idle ? in_chan.func         : func_r;
  assign src_hi   = is_idle ? in_chan.tag_id_hi    : in_hi_r;
  assign src_lo   = is_idle ? in_chan.tag_id_lo    : in_lo_r;
  assign src_ant  = is_idle ? in_chan.antenna      : in_ant_r;
  assign src_cnt  = is_idle ? in_chan.read_count   : in_cnt_r;
  assign src_sig  = is_idle ? in_chan.signal_level : in_sig_r;
  assign src_spd  = is_idle ? in_chan.speed        : in_spd_r;
  assign src_hdg  = is_idle ? in_chan.heading      : in_hdg_r;
  assign src_time = is_idle ? in_chan.timestamp[TIME_W-1:0] : in_time_r;

  assign match = pend_r && (in_chan.tag_id_hi == id_hi_r) &&
                 (in_chan.tag_id_lo == id_lo_r) && (in_chan.antenna == ant_r);

  assign divisor  = (run_len_r == '0) ? RCB'(1) : run_len_r;
  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  assign reads_add = {1'b0, reads_r} + (READS_W + 1)'(in_chan.read_count);
  assign rssi_add  = {1'b0, rssi_sum_r} + (RSSI_SUM_W + 1)'(in_chan.signal_level);
  assign speed_add = {1'b0, speed_sum_r} + (SPEED_SUM_W + 1)'(in_chan.speed);

  // two restoring division steps per cycle
  always_comb begin
    logic [RCB:0]     r;
    logic [DIV_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r = {r[RCB-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        q[0] = 1'b1;
      end
    end
    step_rem = r;
    step_quo = q;
  end

  assign rssi_mean  = (|step_quo[DIV_W-1:SIG_W]) ? '1 : step_quo[SIG_W-1:0];
  assign speed_mean = (|step_quo[DIV_W-1:SPD_W]) ? '1 : step_quo[SPD_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    in_hi_nxt     = in_hi_r;
    in_lo_nxt     = in_lo_r;
    in_ant_nxt    = in_ant_r;
    in_cnt_nxt    = in_cnt_r;
    in_sig_nxt    = in_sig_r;
    in_spd_nxt    = in_spd_r;
    in_hdg_nxt    = in_hdg_r;
    in_time_nxt   = in_time_r;
    pend_nxt      = pend_r;
    id_hi_nxt     = id_hi_r;
    id_lo_nxt     = id_lo_r;
    ant_nxt       = ant_r;
    reads_nxt     = reads_r;
    rssi_sum_nxt  = rssi_sum_r;
    speed_sum_nxt = speed_sum_r;
    run_len_nxt   = run_len_r;
    hdg_nxt       = hdg_r;
    t_first_nxt   = t_first_r;
    t_last_nxt    = t_last_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    rssi_q_nxt    = rssi_q_r;
    o_kind_nxt    = o_kind_r;
    o_hi_nxt      = o_hi_r;
    o_lo_nxt      = o_lo_r;
    o_ant_nxt     = o_ant_r;
    o_reads_nxt   = o_reads_r;
    o_rssi_nxt    = o_rssi_r;
    o_spd_nxt     = o_spd_r;
    o_hdg_nxt     = o_hdg_r;
    o_first_nxt   = o_first_r;
    o_last_nxt    = o_last_r;
    o_lor_nxt     = o_lor_r;
    do_load       = 1'b0;
    do_mark       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_chan.func;
          in_hi_nxt   = in_chan.tag_id_hi;
          in_lo_nxt   = in_chan.tag_id_lo;
          in_ant_nxt  = in_chan.antenna;
          in_cnt_nxt  = in_chan.read_count;
          in_sig_nxt  = in_chan.signal_level;
          in_spd_nxt  = in_chan.speed;
          in_hdg_nxt  = in_chan.heading;
          in_time_nxt = in_chan.timestamp[TIME_W-1:0];
          unique case (in_chan.func)
            FUNC_READ: begin
              if (match) begin
                reads_nxt = reads_add[READS_W] ? '1 : reads_add[READS_W-1:0];
                if (run_len_r != '1) begin
                  rssi_sum_nxt  = rssi_add[RSSI_SUM_W] ? '1 : rssi_add[RSSI_SUM_W-1:0];
                  speed_sum_nxt = speed_add[SPEED_SUM_W] ? '1 :
                                  speed_add[SPEED_SUM_W-1:0];
                  run_len_nxt   = run_len_r + RCB'(1);
                end
                t_last_nxt = in_chan.timestamp[TIME_W-1:0];
              end else if (pend_r) begin
                rem_nxt     = '0;
                quo_nxt     = DIV_W'(rssi_sum_r);
                div_cnt_nxt = '0;
                state_nxt   = S_DIV_RSSI;
              end else begin
                do_load = 1'b1;
              end
            end
            FUNC_START: begin
              pend_nxt  = 1'b0;
              do_mark   = 1'b1;
              state_nxt = S_MARK;
            end
            FUNC_END: begin
              if (pend_r) begin
                rem_nxt     = '0;
                quo_nxt     = DIV_W'(rssi_sum_r);
                div_cnt_nxt = '0;
                state_nxt   = S_DIV_RSSI;
              end else begin
                do_mark   = 1'b1;
                state_nxt = S_MARK;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV_RSSI: begin
        rem_nxt     = step_rem;
        quo_nxt     = step_quo;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          rssi_q_nxt  = rssi_mean;
          rem_nxt     = '0;
          quo_nxt     = DIV_W'(speed_sum_r);
          div_cnt_nxt = '0;
          state_nxt   = S_DIV_SPEED;
        end
      end
      S_DIV_SPEED: begin
        rem_nxt     = step_rem;
        quo_nxt     = step_quo;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          o_kind_nxt  = KIND_RECORD;
          o_hi_nxt    = id_hi_r;
          o_lo_nxt    = id_lo_r;
          o_ant_nxt   = ant_r;
          o_reads_nxt = reads_r;
          o_rssi_nxt  = RSSI_OUT_W'(0) - {1'b0, rssi_q_r};
          o_spd_nxt   = speed_mean;
          o_hdg_nxt   = hdg_r;
          o_first_nxt = TS_W'(t_first_r);
          o_last_nxt  = TS_W'(t_last_r);
          o_lor_nxt   = (func_r == FUNC_READ);
          do_load     = (func_r == FUNC_READ);
          state_nxt   = S_REC;
        end
      end
      S_REC: begin
        if (out_acc) begin
          if (func_r == FUNC_END) begin
            do_mark   = 1'b1;
            state_nxt = S_MARK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_load) begin
      pend_nxt      = 1'b1;
      id_hi_nxt     = src_hi;
      id_lo_nxt     = src_lo;
      ant_nxt       = src_ant;
      reads_nxt     = READS_W'(src_cnt);
      rssi_sum_nxt  = RSSI_SUM_W'(src_sig);
      speed_sum_nxt = SPEED_SUM_W'(src_spd);
      run_len_nxt   = RCB'(1);
      hdg_nxt       = src_hdg;
      t_first_nxt   = src_time;
      t_last_nxt    = src_time;
    end

    if (do_mark) begin
      o_kind_nxt  = (src_func == FUNC_START) ? KIND_START : KIND_END;
      o_hi_nxt    = '0;
      o_lo_nxt    = '0;
      o_ant_nxt   = '0;
      o_reads_nxt = '0;
      o_rssi_nxt  = '0;
      o_spd_nxt   = '0;
      o_hdg_nxt   = '0;
      o_first_nxt = TS_W'(src_time);
      o_last_nxt  = TS_W'(src_time);
      o_lor_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    in_hi_r     <= in_hi_nxt;
    in_lo_r     <= in_lo_nxt;
    in_ant_r    <= in_ant_nxt;
    in_cnt_r    <= in_cnt_nxt;
    in_sig_r    <= in_sig_nxt;
    in_spd_r    <= in_spd_nxt;
    in_hdg_r    <= in_hdg_nxt;
    in_time_r   <= in_time_nxt;
    id_hi_r     <= id_hi_nxt;
    id_lo_r     <= id_lo_nxt;
    ant_r       <= ant_nxt;
    reads_r     <= reads_nxt;
    rssi_sum_r  <= rssi_sum_nxt;
    speed_sum_r <= speed_sum_nxt;
    run_len_r   <= run_len_nxt;
    hdg_r       <= hdg_nxt;
    t_first_r   <= t_first_nxt;
    t_last_r    <= t_last_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    div_cnt_r   <= div_cnt_nxt;
    rssi_q_r    <= rssi_q_nxt;
    o_kind_r    <= o_kind_nxt;
    o_hi_r      <= o_hi_nxt;
    o_lo_r      <= o_lo_nxt;
    o_ant_r     <= o_ant_nxt;
    o_reads_r   <= o_reads_nxt;
    o_rssi_r    <= o_rssi_nxt;
    o_spd_r     <= o_spd_nxt;
    o_hdg_r     <= o_hdg_nxt;
    o_first_r   <= o_first_nxt;
    o_last_r    <= o_last_nxt;
    o_lor_r     <= o_lor_nxt;
  end

  assign out_chan.record_kind = o_kind_r;
  assign out_chan.out_id_hi   = o_hi_r;
  assign out_chan.out_id_lo   = o_lo_r;
  assign out_chan.out_antenna = o_ant_r;
  assign out_chan.total_reads = o_reads_r;
  assign out_chan.mean_rssi   = o_rssi_r;
  assign out_chan.mean_speed  = o_spd_r;
  assign out_chan.out_heading = o_hdg_r;
  assign out_chan.first_seen  = o_first_r;
  assign out_chan.last_seen   = o_last_r;
  assign out_chan.last_of_run = o_lor_r;

endmodule
